/* rtl/i2c_bus_sniffer_message_capture_macros.svh */
// Assertion macros used by the RTL file that checks itself.
`ifndef I2C_BUS_SNIFFER_MESSAGE_CAPTURE_MACROS_SVH
`define I2C_BUS_SNIFFER_MESSAGE_CAPTURE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define I2CBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define I2CBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define I2CBS_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define I2CBS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/i2cbs_pkg.sv */
`timescale 1ns / 1ps

package i2cbs_pkg;

    localparam int STORE_DEPTH_DEF = 32;
    localparam int LEN_W           = 6;
    localparam int BYTE_W          = 8;
    localparam int BITCNT_W        = 4;

    localparam logic [LEN_W-1:0]    LENGTH_RESET = 6'd26;
    localparam logic [BITCNT_W-1:0] DATA_BITS    = 4'd8;
    localparam logic [BYTE_W-1:0]   CODE_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0]   CODE_TILDE   = 8'h7E;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHOW
    } t_state;

    function automatic logic [BYTE_W-1:0] printable_or_space(input logic [BYTE_W-1:0] code);
        logic [BYTE_W-1:0] result;
        result = CODE_SPACE;
        if (code >= CODE_SPACE && code <= CODE_TILDE) begin
            result = code;
        end
        return result;
    endfunction

endpackage

/* rtl/i2cbs_ram.sv */
`timescale 1ns / 1ps

module i2cbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/i2c_bus_sniffer_message_capture.sv */
`timescale 1ns / 1ps
`include "i2c_bus_sniffer_message_capture_macros.svh"
// Passive I2C bus monitor that captures fixed-length messages.
// Input channel (i_in_valid/o_in_ready): one beat carries one sample of the
// SCL and SDA line levels. Edges are found against the previous beat.
// Output channel (o_out_valid/i_out_ready): one beat per captured byte, with
// o_last_byte high on the final byte of a message.
// Configuration channel (i_cfg_valid/o_cfg_ready): writes the message length.
// While no message is being read out, samples stream at one per cycle. A stop
// condition that closes a message stops input for the readout: each byte is
// first read from the message store into a register and then held on the
// output until the receiver takes it. The next sample is taken once the last
// byte of the message has been taken.
// The output is held unchanged while the receiver stalls, and the readout
// simply waits for it.
// Reset returns the line history to idle high, leaves frame mode, clears the
// byte count and sets the message length to 26. The message store is not
// cleared; only written entries are ever read.
module i2c_bus_sniffer_message_capture #(
    parameter int STORE_DEPTH = i2cbs_pkg::STORE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_scl_level,
    input  logic                         i_sda_level,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [i2cbs_pkg::BYTE_W-1:0] o_message_byte,
    output logic                         o_last_byte,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [i2cbs_pkg::LEN_W-1:0]  i_cfg_message_length
);

    localparam int CW    = $clog2(STORE_DEPTH + 1);
    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int CMP_W = (CW > i2cbs_pkg::LEN_W) ? CW : i2cbs_pkg::LEN_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(STORE_DEPTH);

    i2cbs_pkg::t_state r_state, n_state;

    logic                              r_prev_scl, n_prev_scl;
    logic                              r_prev_sda, n_prev_sda;
    logic                              r_in_frame, n_in_frame;
    logic [i2cbs_pkg::BITCNT_W-1:0]    r_bit_cnt, n_bit_cnt;
    logic [i2cbs_pkg::BYTE_W-1:0]      r_shift, n_shift;
    logic [CW-1:0]                     r_count, n_count;
    logic [i2cbs_pkg::LEN_W-1:0]       r_msg_len, n_msg_len;
    logic [AW-1:0]                     r_rd_idx, n_rd_idx;
    logic [CW-1:0]                     r_rd_len, n_rd_len;

    logic                              w_in_acc;
    logic                              w_wr_en;
    logic                              w_emit;
    logic                              w_rd_en;
    logic [CMP_W-1:0]                  w_cnt_ext;
    logic [CMP_W-1:0]                  w_len_ext;
    logic [i2cbs_pkg::BYTE_W-1:0]      w_rd_data;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_cnt_ext = CMP_W'(r_count);
    assign w_len_ext = CMP_W'(r_msg_len);

    always_comb begin
        n_prev_scl = r_prev_scl;
        n_prev_sda = r_prev_sda;
        n_in_frame = r_in_frame;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;
        n_count    = r_count;
        n_msg_len  = r_msg_len;
        n_rd_idx   = r_rd_idx;
        n_rd_len   = r_rd_len;
        w_wr_en    = 1'b0;
        w_emit     = 1'b0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_msg_len = i_cfg_message_length;
        end

        if (w_in_acc) begin
            n_prev_scl = i_scl_level;
            n_prev_sda = i_sda_level;
            if (i_scl_level != r_prev_scl) begin
                if (i_scl_level && r_in_frame) begin
                    if (r_bit_cnt < i2cbs_pkg::DATA_BITS) begin
                        n_shift   = {r_shift[i2cbs_pkg::BYTE_W-2:0], i_sda_level};
                        n_bit_cnt = r_bit_cnt + 1'b1;
                    end else begin
                        if (w_cnt_ext >= w_len_ext || w_cnt_ext >= DEPTH_C) begin
                            n_count = '0;
                        end else begin
                            w_wr_en = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                        n_bit_cnt = '0;
                        n_shift   = '0;
                    end
                end
            end else if (i_sda_level != r_prev_sda && i_scl_level) begin
                n_bit_cnt = '0;
                n_shift   = '0;
                if (i_sda_level) begin
                    n_in_frame = 1'b0;
                    if (w_cnt_ext == w_len_ext && r_count != '0) begin
                        w_emit   = 1'b1;
                        n_rd_len = r_count;
                        n_rd_idx = '0;
                    end
                    n_count = '0;
                end else begin
                    n_in_frame = 1'b1;
                end
            end
            if (CMP_W'(n_count) > w_len_ext) begin
                n_count = '0;
            end
        end

        if (r_state == i2cbs_pkg::ST_SHOW && i_out_ready) begin
            n_rd_idx = r_rd_idx + 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            i2cbs_pkg::ST_IDLE: begin
                if (w_emit) begin
                    n_state = i2cbs_pkg::ST_READ;
                end
            end
            i2cbs_pkg::ST_READ: begin
                n_state = i2cbs_pkg::ST_SHOW;
            end
            i2cbs_pkg::ST_SHOW: begin
                if (i_out_ready) begin
                    n_state = o_last_byte ? i2cbs_pkg::ST_IDLE : i2cbs_pkg::ST_READ;
                end
            end
            default: begin
                n_state = i2cbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        o_out_valid = 1'b0;
        w_rd_en     = 1'b0;
        unique case (r_state)
            i2cbs_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cfg_ready = 1'b1;
            end
            i2cbs_pkg::ST_READ: begin
                w_rd_en = 1'b1;
            end
            i2cbs_pkg::ST_SHOW: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign o_last_byte = (CW'(r_rd_idx) + CW'(1)) == r_rd_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= i2cbs_pkg::ST_IDLE;
            r_prev_scl <= 1'b1;
            r_prev_sda <= 1'b1;
            r_in_frame <= 1'b0;
            r_bit_cnt  <= '0;
            r_shift    <= '0;
            r_count    <= '0;
            r_msg_len  <= i2cbs_pkg::LENGTH_RESET;
        end else begin
            r_state    <= n_state;
            r_prev_scl <= n_prev_scl;
            r_prev_sda <= n_prev_sda;
            r_in_frame <= n_in_frame;
            r_bit_cnt  <= n_bit_cnt;
            r_shift    <= n_shift;
            r_count    <= n_count;
            r_msg_len  <= n_msg_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        r_rd_len <= n_rd_len;
    end

    i2cbs_ram #(
        .WIDTH(i2cbs_pkg::BYTE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i2cbs_pkg::printable_or_space(r_shift)),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (w_rd_data)
    );

    assign o_message_byte = w_rd_data;

    `I2CBS_ASSERT_IMP(a_count_in_range, i_clk, i_rst_n, 1'b1, CMP_W'(r_count) <= DEPTH_C)
    `I2CBS_ASSERT_IMP(a_no_input_in_readout, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `I2CBS_ASSERT_NXT(a_last_ends_readout, i_clk, i_rst_n, o_out_valid && i_out_ready && o_last_byte, o_in_ready)
    `I2CBS_ASSERT_NXT(a_readout_continues, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last_byte, !o_in_ready && !o_out_valid)

endmodule
